// File: rtl/vha_pkg.sv
// ----------------------------------------------------------------------------
// vha_pkg
// Shared types, codes and defaults for the versioned handle allocator.
// ----------------------------------------------------------------------------
package vha_pkg;

  // fixed field widths
  localparam int HANDLE_W = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 15;

  // parameter defaults
  localparam int CAPACITY_DEF     = 16384;
  localparam int INDEX_BITS_DEF   = 20;
  localparam int VERSION_BITS_DEF = 12;

  // request opcodes
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // latch request and read the table
    logic exec;    // evaluate, write back, present result
  } cmd_t;

endpackage

// File: rtl/vha_ctrl.sv
// ----------------------------------------------------------------------------
// vha_ctrl
// Two-state sequencer: table read on accept, then evaluate and write back.
// ----------------------------------------------------------------------------
module vha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output vha_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign busy       = (state_r == ST_EXEC);
  assign cmd.accept = start && (state_r == ST_IDLE);
  assign cmd.exec   = (state_r == ST_EXEC);

endmodule

// File: rtl/vha_dp.sv
// ----------------------------------------------------------------------------
// vha_dp
// Entry table, free-list head, counters and result registers.
// ----------------------------------------------------------------------------
module vha_dp #(
  parameter int CAPACITY     = vha_pkg::CAPACITY_DEF,
  parameter int INDEX_BITS   = vha_pkg::INDEX_BITS_DEF,
  parameter int VERSION_BITS = vha_pkg::VERSION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vha_pkg::cmd_t                  cmd,
  input  logic [vha_pkg::OP_W-1:0]       in_op,
  input  logic [vha_pkg::HANDLE_W-1:0]   in_handle,
  output logic                           out_valid,
  output logic [vha_pkg::HANDLE_W-1:0]   out_new_handle,
  output logic                           out_handle_valid,
  output logic [vha_pkg::STATUS_W-1:0]   out_status,
  output logic [vha_pkg::COUNT_W-1:0]    out_entries_used,
  output logic [vha_pkg::COUNT_W-1:0]    out_alive_count
);

  localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int HW        = vha_pkg::HANDLE_W;

  localparam logic [63:0] IDX_MASK64 = (64'd1 << INDEX_BITS) - 64'd1;
  localparam logic [63:0] VER_FIELD64 =
    (((64'd1 << VERSION_BITS) - 64'd1) << INDEX_BITS) & 64'hFFFF_FFFF;
  localparam logic [63:0] VER_ONE64 = 64'd1 << INDEX_BITS;

  // request registers
  logic [vha_pkg::OP_W-1:0] op_r;
  logic [HW-1:0]            handle_r;

  // allocator state
  logic [CNT_BITS-1:0]   used_r,  used_nxt;
  logic [CNT_BITS-1:0]   free_r,  free_nxt;
  logic [INDEX_BITS-1:0] head_r,  head_nxt;

  // entry table
  logic [HW-1:0]        mem [CAPACITY];
  logic [HW-1:0]        rd_r;
  logic [ADDR_BITS-1:0] mem_addr;
  logic                 mem_we;
  logic [HW-1:0]        mem_wdata;
  logic [ADDR_BITS-1:0] wr_addr;

  // evaluation
  logic [INDEX_BITS-1:0]        h_idx;
  logic [INDEX_BITS-1:0]        rd_idx;
  logic                         live;
  logic                         full;
  logic [INDEX_BITS-1:0]        link;
  logic [63:0]                  ver_bump;
  logic [HW-1:0]                nh_nxt;
  logic                         hv_nxt;
  logic [vha_pkg::STATUS_W-1:0] st_nxt;

  // result registers
  logic                         out_valid_r;
  logic [HW-1:0]                nh_r;
  logic                         hv_r;
  logic [vha_pkg::STATUS_W-1:0] st_r;
  logic [vha_pkg::COUNT_W-1:0]  used_out_r;
  logic [vha_pkg::COUNT_W-1:0]  alive_out_r;

  // read index at accept: free-list head for create, handle index otherwise
  assign rd_idx   = (in_op == vha_pkg::OP_CREATE) ? head_r : in_handle[INDEX_BITS-1:0];
  assign mem_addr = cmd.exec ? wr_addr : ADDR_BITS'(rd_idx);

  // single-port table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.accept) begin
      rd_r <= mem[mem_addr];
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_op;
      handle_r <= in_handle;
    end
  end

  // liveness and fullness
  assign h_idx = handle_r[INDEX_BITS-1:0];
  assign live  = (64'(h_idx) < 64'(used_r)) && (rd_r == handle_r);
  assign full  = (64'(used_r) >= 64'(CAPACITY)) || (64'(used_r) >= IDX_MASK64);
  assign link  = (free_r != '0) ? head_r : (h_idx + INDEX_BITS'(1));
  assign ver_bump = ((64'(handle_r) & VER_FIELD64) + VER_ONE64) & VER_FIELD64;

  // operation evaluation
  always_comb begin
    used_nxt  = used_r;
    free_nxt  = free_r;
    head_nxt  = head_r;
    mem_we    = 1'b0;
    mem_wdata = '0;
    wr_addr   = ADDR_BITS'(h_idx);
    nh_nxt    = '0;
    hv_nxt    = 1'b0;
    st_nxt    = vha_pkg::STAT_OK;
    unique case (op_r)
      vha_pkg::OP_CREATE: begin
        if (free_r != '0) begin
          // pop the free-list head, keep its stored version
          nh_nxt    = HW'(64'(head_r) | (64'(rd_r) & VER_FIELD64));
          head_nxt  = rd_r[INDEX_BITS-1:0];
          free_nxt  = free_r - CNT_BITS'(1);
          wr_addr   = ADDR_BITS'(head_r);
          mem_we    = cmd.exec;
          mem_wdata = nh_nxt;
        end else if (full) begin
          st_nxt = vha_pkg::STAT_FULL;
        end else begin
          // append a fresh index at version zero
          nh_nxt    = HW'(used_r);
          used_nxt  = used_r + CNT_BITS'(1);
          wr_addr   = ADDR_BITS'(used_r);
          mem_we    = cmd.exec;
          mem_wdata = HW'(used_r);
        end
      end
      vha_pkg::OP_DESTROY: begin
        if (!live) begin
          st_nxt = vha_pkg::STAT_INVALID;
        end else begin
          // bump version, link to old head, push
          mem_we    = cmd.exec;
          mem_wdata = HW'(64'(link) | ver_bump);
          head_nxt  = h_idx;
          free_nxt  = free_r + CNT_BITS'(1);
        end
      end
      vha_pkg::OP_CHECK: begin
        hv_nxt = live;
      end
      vha_pkg::OP_CLEAR: begin
        used_nxt = '0;
        free_nxt = '0;
        head_nxt = '1;
      end
      default: begin
        st_nxt = vha_pkg::STAT_OK;
      end
    endcase
  end

  // allocator state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      free_r <= '0;
      head_r <= '1;
    end else if (cmd.exec) begin
      used_r <= used_nxt;
      free_r <= free_nxt;
      head_r <= head_nxt;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      nh_r        <= nh_nxt;
      hv_r        <= hv_nxt;
      st_r        <= st_nxt;
      used_out_r  <= vha_pkg::COUNT_W'(used_nxt);
      alive_out_r <= vha_pkg::COUNT_W'(used_nxt - free_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_handle   = nh_r;
  assign out_handle_valid = hv_r;
  assign out_status       = st_r;
  assign out_entries_used = used_out_r;
  assign out_alive_count  = alive_out_r;

  // free list never holds more entries than were appended
  a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= used_r)
    else $error("free count exceeds used count");

  // an empty free list after clear means head is null
  a_clear_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r == vha_pkg::OP_CLEAR |=> head_r == '1 && used_r == '0)
    else $error("clear left allocator state behind");

  // a full report never carries a handle
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r == vha_pkg::STAT_FULL |-> nh_r == '0)
    else $error("full status with nonzero handle");

endmodule

// File: rtl/versioned_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// versioned_handle_allocator_core
// Hands out index/version handles and recycles freed indices through a free
// list threaded through the entry table.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------------
//   request | in_op, in_handle                        | start high, busy low
//   result  | out_new_handle, out_handle_valid,       | out_valid strobe,
//           | out_status, out_entries_used,           | one cycle, no stall
//           | out_alive_count                         |
//
// For each request the table is read at the accept edge, and the entry is
// evaluated and written back over the single table port in the next cycle.
// The result strobe follows in the cycle after that, and the next request
// may be accepted in the same cycle as the strobe.
// Reset empties the allocator; the table itself is not cleared, and only
// entries below the used count can test as live.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module versioned_handle_allocator_core #(
  parameter int CAPACITY     = vha_pkg::CAPACITY_DEF,
  parameter int INDEX_BITS   = vha_pkg::INDEX_BITS_DEF,
  parameter int VERSION_BITS = vha_pkg::VERSION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [vha_pkg::OP_W-1:0]       in_op,
  input  logic [vha_pkg::HANDLE_W-1:0]   in_handle,
  output logic                           out_valid,
  output logic [vha_pkg::HANDLE_W-1:0]   out_new_handle,
  output logic                           out_handle_valid,
  output logic [vha_pkg::STATUS_W-1:0]   out_status,
  output logic [vha_pkg::COUNT_W-1:0]    out_entries_used,
  output logic [vha_pkg::COUNT_W-1:0]    out_alive_count
);

  vha_pkg::cmd_t cmd;

  // sequencer
  vha_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // table and counters
  vha_dp #(
    .CAPACITY     (CAPACITY),
    .INDEX_BITS   (INDEX_BITS),
    .VERSION_BITS (VERSION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_op            (in_op),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_new_handle   (out_new_handle),
    .out_handle_valid (out_handle_valid),
    .out_status       (out_status),
    .out_entries_used (out_entries_used),
    .out_alive_count  (out_alive_count)
  );

  // accepted request moves to the evaluate cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not start");

  // evaluate cycle is followed by exactly one result strobe
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("result strobe missing after evaluation");

  // a strobe only follows an evaluate cycle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("spurious result strobe");

endmodule
